// ===== rtl/core/tdd_pkg.sv =====
// Shared types and constants for the trial division divisor lister.
// Used by every module under rtl/core except tdd_divider; depends on nothing.
package tdd_pkg;

  localparam int unsigned NUMBER_WIDTH = 16;
  localparam int unsigned NUMBER_W     = 16;
  localparam int unsigned SMALL_W      = 8;
  localparam int unsigned LARGE_W      = 16;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 24;
  localparam int unsigned OUT_TUSER_W  = 3;

  typedef struct packed {
    logic load_num;
    logic start_div;
    logic inc_div;
    logic store_pend;
    logic push_pend;
    logic push_last;
    logic push_zero;
  } tdd_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic pend_valid;
    logic out_free;
  } tdd_sts_t;

endpackage

// ===== rtl/core/trial_division_divisor_lister.sv =====
// Top level of the trial division divisor lister and primality test.
// Depends on tdd_pkg, tdd_ctrl, tdd_datapath and tdd_divider.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid_i/tready_o     tdata[15:0] number
//   m_axis    out  m_axis_tvalid_o/tready_i     tdata: small, large; tuser: flags; tlast
//
// Each trial divisor d passes a square test that starts the divider, NUMBER_WIDTH divider
// steps and a result check, and one step more when d divides; a zero number skips the
// trial divisions. One number is worked at a time; the next is taken once the last
// pair is registered. A stalled output holds the controller only when a new pair must leave.
// Reset clears the controller, the valid flags and the counters.
module trial_division_divisor_lister #(
  parameter int unsigned NUMBER_WIDTH = tdd_pkg::NUMBER_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [tdd_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // [15:0] number
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tdd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,  // [7:0] small_divisor,
                                                             // [23:8] large_divisor
  output logic [tdd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o,  // [0] pair_valid,
                                                             // [1] single_root, [2] is_prime
  output logic                              m_axis_tlast_o
);

  tdd_pkg::tdd_cmd_t             cmd;
  tdd_pkg::tdd_sts_t             sts;
  logic [tdd_pkg::SMALL_W-1:0]   small_divisor;
  logic [tdd_pkg::LARGE_W-1:0]   large_divisor;
  logic                          pair_valid, single_root, is_prime;

  tdd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tdd_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .number_i       (s_axis_tdata_i[tdd_pkg::NUMBER_W-1:0]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .small_divisor_o(small_divisor),
    .large_divisor_o(large_divisor),
    .pair_valid_o   (pair_valid),
    .single_root_o  (single_root),
    .is_prime_o     (is_prime),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {large_divisor, small_divisor};
  assign m_axis_tuser_o = {is_prime, single_root, pair_valid};

endmodule

// ===== rtl/core/tdd_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module tdd_divider #(
  parameter int unsigned NUMBER_WIDTH = 16,
  parameter int unsigned DIV_W        = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUMBER_WIDTH-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic [NUMBER_WIDTH-1:0] quot_o,
  output logic [DIV_W-1:0]        rem_o
);

  localparam int unsigned CNT_W = $clog2(NUMBER_WIDTH + 1);

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [NUMBER_WIDTH-1:0] quot_q, quot_d;
  logic [DIV_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]        dsr_q, dsr_d;
  logic [DIV_W:0]          trial;
  logic                    fits;

  assign trial = {rem_q, quot_q[NUMBER_WIDTH-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUMBER_WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      quot_d = {quot_q[NUMBER_WIDTH-2:0], fits};
      rem_d  = fits ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/tdd_datapath.sv =====
// Datapath: held number, trial divisor, square test, pending pair and output register.
// Depends on tdd_pkg and tdd_divider.
module tdd_datapath #(
  parameter int unsigned NUMBER_WIDTH = tdd_pkg::NUMBER_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tdd_pkg::tdd_cmd_t              cmd_i,
  output tdd_pkg::tdd_sts_t              sts_o,
  input  logic [tdd_pkg::NUMBER_W-1:0]   number_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [tdd_pkg::SMALL_W-1:0]    small_divisor_o,
  output logic [tdd_pkg::LARGE_W-1:0]    large_divisor_o,
  output logic                           pair_valid_o,
  output logic                           single_root_o,
  output logic                           is_prime_o,
  output logic                           last_o
);

  localparam int unsigned DW    = (NUMBER_WIDTH + 1) / 2;
  localparam int unsigned DIV_W = DW + 1;
  localparam int unsigned SQ_W  = 2 * DIV_W;

  logic [NUMBER_WIDTH-1:0]      num_q;
  logic [DIV_W-1:0]             div_q;
  logic [tdd_pkg::COUNT_W-1:0]  cnt_q;
  logic                         pend_valid_q;
  logic [DW-1:0]                pend_small_q;
  logic [NUMBER_WIDTH-1:0]      pend_large_q;
  logic                         pend_root_q;
  logic                         out_valid_q;
  logic [tdd_pkg::SMALL_W-1:0]  out_small_q;
  logic [tdd_pkg::LARGE_W-1:0]  out_large_q;
  logic                         out_pair_q, out_root_q, out_prime_q, out_last_q;
  logic [SQ_W-1:0]              sq;
  logic                         div_done;
  logic [NUMBER_WIDTH-1:0]      quot;
  logic [DIV_W-1:0]             rem;
  logic                         out_free;
  logic                         push;

  tdd_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .DIV_W       (DIV_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_div),
    .dividend_i(num_q),
    .divisor_i (div_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign sq       = div_q * div_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = cmd_i.push_pend || cmd_i.push_zero;

  assign sts_o.n_zero     = (num_q == '0);
  assign sts_o.sq_gt      = sq > SQ_W'(num_q);
  assign sts_o.div_done   = div_done;
  assign sts_o.rem_zero   = (rem == '0);
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q        <= DIV_W'(1);
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load_num) begin
        div_q        <= DIV_W'(1);
        cnt_q        <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        if (cmd_i.inc_div) begin
          div_q <= div_q + 1'b1;
        end
        if (cmd_i.store_pend) begin
          cnt_q        <= cnt_q + 1'b1;
          pend_valid_q <= 1'b1;
        end else if (cmd_i.push_pend) begin
          pend_valid_q <= 1'b0;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_num) begin
      num_q <= number_i[NUMBER_WIDTH-1:0];
    end
    if (cmd_i.store_pend) begin
      pend_small_q <= div_q[DW-1:0];
      pend_large_q <= quot;
      pend_root_q  <= (quot == NUMBER_WIDTH'(div_q));
    end
    if (cmd_i.push_zero) begin
      out_small_q <= '0;
      out_large_q <= '0;
      out_pair_q  <= 1'b0;
      out_root_q  <= 1'b0;
      out_prime_q <= 1'b0;
      out_last_q  <= 1'b1;
    end else if (cmd_i.push_pend) begin
      out_small_q <= tdd_pkg::SMALL_W'(pend_small_q);
      out_large_q <= tdd_pkg::LARGE_W'(pend_large_q);
      out_pair_q  <= 1'b1;
      out_root_q  <= pend_root_q;
      out_prime_q <= cmd_i.push_last && (cnt_q == tdd_pkg::COUNT_W'(1))
                     && (num_q != NUMBER_WIDTH'(1));
      out_last_q  <= cmd_i.push_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign small_divisor_o = out_small_q;
  assign large_divisor_o = out_large_q;
  assign pair_valid_o    = out_pair_q;
  assign single_root_o   = out_root_q;
  assign is_prime_o      = out_prime_q;
  assign last_o          = out_last_q;

endmodule

// ===== rtl/core/tdd_ctrl.sv =====
// Controller: sequences the trial divisions and the release of divisor pairs.
// Depends on tdd_pkg.
module tdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdd_pkg::tdd_sts_t sts_i,
  output tdd_pkg::tdd_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PAIR  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_ZERO  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_num = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.n_zero) begin
          state_d = S_ZERO;
        end else if (sts_i.sq_gt) begin
          state_d = S_FIN;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            state_d = S_PAIR;
          end else begin
            cmd_o.inc_div = 1'b1;
            state_d       = S_CHECK;
          end
        end
      end
      S_PAIR: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.push_pend  = sts_i.pend_valid;
          cmd_o.store_pend = 1'b1;
          cmd_o.inc_div    = 1'b1;
          state_d          = S_CHECK;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.push_pend = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.push_zero = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== bench/trial_division_divisor_lister_tb.sv =====
// Testbench for trial_division_divisor_lister: checks every divisor pair and primality verdict
// against a behavioral predictor, under phases of source idling, sink stalls and backpressure.
// Depends on tdd_pkg and the trial_division_divisor_lister RTL.
`timescale 1ns / 1ps

module trial_division_divisor_lister_tb;

  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 5000;

  typedef struct packed {
    logic [tdd_pkg::SMALL_W-1:0] sm_div;
    logic [tdd_pkg::LARGE_W-1:0] lg_div;
    logic                        pair_ok;
    logic                        root_once;
    logic                        prime;
    logic                        final_pair;
  } divisor_pair_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_valid = 1'b0;
  logic                            s_ready;
  logic [tdd_pkg::IN_TDATA_W-1:0]  s_data = '0;
  logic                            m_valid;
  logic                            m_ready = 1'b0;
  logic [tdd_pkg::OUT_TDATA_W-1:0] m_data;
  logic [tdd_pkg::OUT_TUSER_W-1:0] m_user;
  logic                            m_last;

  logic [tdd_pkg::NUMBER_W-1:0] numbers_to_send[$];
  divisor_pair_t                pending_pairs[$];
  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_stall_pct = 0;
  bit                           pressure_on = 1'b0;
  logic                         rx_hold = 1'b0;
  int unsigned                  mismatch_count = 0;

  trial_division_divisor_lister DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void list_divisor_pairs(input logic [tdd_pkg::NUMBER_W-1:0] n);
    divisor_pair_t p;
    int unsigned   d;
    int unsigned   found;
    found = 0;
    p = '0;
    if (n == '0) begin
      p.final_pair = 1'b1;
      pending_pairs.push_back(p);
    end else begin
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          p = '0;
          p.sm_div    = tdd_pkg::SMALL_W'(d);
          p.lg_div    = tdd_pkg::LARGE_W'(n / d);
          p.pair_ok   = 1'b1;
          p.root_once = (d * d == n);
          pending_pairs.push_back(p);
          found++;
        end
      end
      p = pending_pairs.pop_back();
      p.prime      = (found == 1) && (n > 1);
      p.final_pair = 1'b1;
      pending_pairs.push_back(p);
    end
  endfunction

  function automatic logic [tdd_pkg::NUMBER_W-1:0] pick_number();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 15) begin
      return tdd_pkg::NUMBER_W'($urandom_range(65535));
    end else if (r < 22) begin
      k = $urandom_range(255);
      return tdd_pkg::NUMBER_W'(k * k);
    end else if (r < 27) begin
      return tdd_pkg::NUMBER_W'($urandom_range(2, 61) * $urandom_range(2, 61) *
                                $urandom_range(1, 8));
    end
    return tdd_pkg::NUMBER_W'($urandom_range(2047));
  endfunction

  task automatic report_mismatch(input string what, input divisor_pair_t want,
                                 input divisor_pair_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected small=%0d large=%0d valid=%0b root=%0b prime=%0b last=%0b",
               what, want.sm_div, want.lg_div, want.pair_ok, want.root_once, want.prime,
               want.final_pair);
      $display("  got small=%0d large=%0d valid=%0b root=%0b prime=%0b last=%0b",
               got.sm_div, got.lg_div, got.pair_ok, got.root_once, got.prime,
               got.final_pair);
    end
  endtask

  task automatic drain();
    while (numbers_to_send.size() > 0 || s_valid || pending_pairs.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) numbers_to_send.push_back(pick_number());
    drain();
  endtask

  // source side: hold the item until its transfer, then advance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_ready) list_divisor_pairs(s_data);
      if (!s_valid || s_ready) begin
        if (numbers_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= numbers_to_send.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    divisor_pair_t got;
    divisor_pair_t want;
    if (rst_n && m_valid && m_ready) begin
      got.sm_div     = m_data[tdd_pkg::SMALL_W-1:0];
      got.lg_div     = m_data[tdd_pkg::SMALL_W +: tdd_pkg::LARGE_W];
      got.pair_ok    = m_user[0];
      got.root_once  = m_user[1];
      got.prime      = m_user[2];
      got.final_pair = m_last;
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = pending_pairs.pop_front();
        if (got.sm_div !== want.sm_div || got.lg_div !== want.lg_div ||
            got.pair_ok !== want.pair_ok || got.root_once !== want.root_once ||
            got.prime !== want.prime || got.final_pair !== want.final_pair) begin
          report_mismatch("pair mismatch", want, got);
        end
      end
    end
  end

  // hold the sink off for a long stretch while the source keeps offering
  initial begin
    wait (pressure_on);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [tdd_pkg::NUMBER_W-1:0] directed[$];
    logic [tdd_pkg::NUMBER_W-1:0] crowded[$];
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd16, 16'd25, 16'd36,
                 16'd12, 16'd97, 16'd55440, 16'd65535, 16'd65534, 16'd65521, 16'd65025,
                 16'd32768, 16'hAAAA, 16'h5555, 16'd1, 16'd0};
    crowded  = '{16'd720, 16'd840, 16'd1008, 16'd900, 16'd1260, 16'd960, 16'd1680,
                 16'd2520};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) numbers_to_send.push_back(directed[i]);
    drain();

    run_random(0, 0, 30);
    run_random(88, 0, 30);
    run_random(0, 88, 30);
    run_random(19, 19, 22);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b1;
    foreach (crowded[i]) numbers_to_send.push_back(crowded[i]);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pairs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tdd_pkg.sv
rtl/core/tdd_divider.sv
rtl/core/tdd_datapath.sv
rtl/core/tdd_ctrl.sv
rtl/core/trial_division_divisor_lister.sv
bench/trial_division_divisor_lister_tb.sv
